@@ rtl/ibfsm_pkg.sv @@
`default_nettype none
package ibfsm_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [1:0] FN_ALLOC_INODE = 2'd0;
    localparam logic [1:0] FN_FREE_INODE  = 2'd1;
    localparam logic [1:0] FN_ALLOC_BLOCK = 2'd2;
    localparam logic [1:0] FN_FREE_BLOCK  = 2'd3;

    localparam logic [1:0] REG_INODE_BASE = 2'd0;
    localparam logic [1:0] REG_INODE_LG   = 2'd1;
    localparam logic [1:0] REG_BLOCK_BASE = 2'd2;
    localparam logic [1:0] REG_BLOCK_LG   = 2'd3;

    localparam logic [31:0] INODE_BASE_RST = 32'd0;
    localparam logic [3:0]  INODE_LG_RST   = 4'd7;
    localparam logic [31:0] BLOCK_BASE_RST = 32'd0;
    localparam logic [4:0]  BLOCK_LG_RST   = 5'd10;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NONE_FREE = 3'd1,
        STAT_RANGE     = 3'd2,
        STAT_NOTHING   = 3'd3,
        STAT_NOT_USED  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOC,
        ST_FRD,
        ST_IRD,
        ST_IEVAL,
        ST_IFREE,
        ST_SRD,
        ST_SPOP,
        ST_BFREE,
        ST_SHIFT,
        ST_ADD,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [31:0] inode_base;
        logic [3:0]  inode_lg;
        logic [31:0] block_base;
        logic [4:0]  block_lg;
    } t_cfg;

endpackage
`default_nettype wire

@@ rtl/inode_and_block_free_space_manager.sv @@
// Request path through the states: a free goes LOC, FRD, IFREE or BFREE, then FIN (LOC goes
// straight to FIN when the range or count check rejects it); a block allocation goes SRD, SPOP,
// SHIFT, ADD, FIN; a refused allocation goes straight to FIN; an inode allocation repeats IRD,
// IEVAL for each 32-entry bitmap row scanned, then SHIFT, ADD, FIN. One request at a time; the
// next is taken once the result is registered, and a result still waiting on i_m_tready holds
// the following one back. Reset is synchronous and active low; then a clearing pass runs.
`default_nettype none
module inode_and_block_free_space_manager #(
    parameter int INODE_COUNT = 128,
    parameter int BLOCK_COUNT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] addr
    input  wire logic [1:0]  i_s_tuser,   // [1:0] func
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // [2:0] status, [34:3] alloc_addr, zero above
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ibfsm_pkg::t_cfg cfg;
    logic [2:0]      status;
    logic [31:0]     alloc_addr;

    ibfsm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ibfsm_ctrl #(
        .INODE_COUNT (INODE_COUNT),
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_func       (i_s_tuser),
        .i_addr       (i_s_tdata),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_status     (status),
        .o_alloc_addr (alloc_addr)
    );

    assign o_m_tdata = {5'd0, alloc_addr, status};

endmodule
`default_nettype wire

@@ rtl/ibfsm_ram.sv @@
`default_nettype none
module ibfsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/ibfsm_cfg.sv @@
`default_nettype none
module ibfsm_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output ibfsm_pkg::t_cfg    o_cfg
);

    ibfsm_pkg::t_cfg r_cfg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inode_base <= ibfsm_pkg::INODE_BASE_RST;
            r_cfg.inode_lg   <= ibfsm_pkg::INODE_LG_RST;
            r_cfg.block_base <= ibfsm_pkg::BLOCK_BASE_RST;
            r_cfg.block_lg   <= ibfsm_pkg::BLOCK_LG_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                ibfsm_pkg::REG_INODE_BASE: r_cfg.inode_base <= pwdata;
                ibfsm_pkg::REG_INODE_LG:   r_cfg.inode_lg   <= pwdata[3:0];
                ibfsm_pkg::REG_BLOCK_BASE: r_cfg.block_base <= pwdata;
                ibfsm_pkg::REG_BLOCK_LG:   r_cfg.block_lg   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ibfsm_pkg::REG_INODE_BASE: prdata = r_cfg.inode_base;
            ibfsm_pkg::REG_INODE_LG:   prdata = {28'd0, r_cfg.inode_lg};
            ibfsm_pkg::REG_BLOCK_BASE: prdata = r_cfg.block_base;
            ibfsm_pkg::REG_BLOCK_LG:   prdata = {27'd0, r_cfg.block_lg};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/ibfsm_ctrl.sv @@
`default_nettype none
module ibfsm_ctrl #(
    parameter int INODE_COUNT = 128,
    parameter int BLOCK_COUNT = 1024
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ibfsm_pkg::t_cfg i_cfg,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire logic [1:0]      i_func,
    input  wire logic [31:0]     i_addr,
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    output logic [2:0]           o_status,
    output logic [31:0]          o_alloc_addr
);

    localparam int IROWS = (INODE_COUNT + ibfsm_pkg::WORD_W - 1) / ibfsm_pkg::WORD_W;
    localparam int IRW   = (IROWS > 1) ? $clog2(IROWS) : 1;
    localparam int IW    = $clog2(INODE_COUNT);
    localparam int BW    = $clog2(BLOCK_COUNT);
    localparam int XW    = (IW > BW) ? IW : BW;
    localparam int ICW   = $clog2(INODE_COUNT + 1);
    localparam int CLR_N = (IROWS > BLOCK_COUNT) ? IROWS : BLOCK_COUNT;
    localparam int CLW   = $clog2(CLR_N);

    ibfsm_pkg::t_state  r_state, n_state;
    ibfsm_pkg::t_status r_stat, n_stat;
    logic [CLW-1:0]     r_clr, n_clr;
    logic [1:0]         r_func, n_func;
    logic [31:0]        r_off, n_off;
    logic [XW-1:0]      r_idx, n_idx;
    logic [IRW-1:0]     r_row, n_row;
    logic [ICW-1:0]     r_icnt, n_icnt;
    logic [BW-1:0]      r_bcnt, n_bcnt;
    logic [31:0]        r_res, n_res;
    logic               r_ovalid, n_ovalid;
    logic [2:0]         r_ostat, n_ostat;
    logic [31:0]        r_oaddr, n_oaddr;

    logic               iwe;
    logic [IRW-1:0]     iwaddr, iraddr;
    logic [31:0]        iwdata, irdata;
    logic               bwe;
    logic [BW-1:0]      bwaddr, braddr;
    logic               bwdata, brdata;
    logic               swe;
    logic [BW-1:0]      swaddr, sraddr;
    logic [BW-1:0]      swdata, srdata;

    logic [31:0]        pad, word, row_base, idx32, lmask, lfull, ifound;
    logic [4:0]         zpos, sh;
    logic               zfound, is_inode;
    logic [IRW-1:0]     fsel_row;
    logic [4:0]         fsel_bit;

    ibfsm_ram #(.WIDTH(ibfsm_pkg::WORD_W), .DEPTH(IROWS)) u_inode_ram (
        .i_clk   (i_clk),
        .i_we    (iwe),
        .i_waddr (iwaddr),
        .i_wdata (iwdata),
        .i_raddr (iraddr),
        .o_rdata (irdata)
    );

    ibfsm_ram #(.WIDTH(1), .DEPTH(BLOCK_COUNT)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (bwe),
        .i_waddr (bwaddr),
        .i_wdata (bwdata),
        .i_raddr (braddr),
        .o_rdata (brdata)
    );

    ibfsm_ram #(.WIDTH(BW), .DEPTH(BLOCK_COUNT)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (swe),
        .i_waddr (swaddr),
        .i_wdata (swdata),
        .i_raddr (sraddr),
        .o_rdata (srdata)
    );

    assign o_s_tready   = (r_state == ibfsm_pkg::ST_IDLE);
    assign o_m_tvalid   = r_ovalid;
    assign o_status     = r_ostat;
    assign o_alloc_addr = r_oaddr;

    // Bits past the last inode of the final row count as used, so the scan never picks them.
    assign row_base = 32'(r_row) << 5;
    always_comb begin
        for (int b = 0; b < 32; b++) begin
            pad[b] = ((row_base + 32'(b)) >= 32'(INODE_COUNT));
        end
    end
    assign word = irdata | pad;

    always_comb begin
        zpos   = 5'd0;
        zfound = 1'b0;
        for (int b = 31; b >= 0; b--) begin
            if (!word[b]) begin
                zpos   = 5'(b);
                zfound = 1'b1;
            end
        end
    end
    assign ifound = row_base | 32'(zpos);

    assign is_inode = (r_func == ibfsm_pkg::FN_ALLOC_INODE) ||
                      (r_func == ibfsm_pkg::FN_FREE_INODE);
    assign sh       = is_inode ? {1'b0, i_cfg.inode_lg} : i_cfg.block_lg;
    assign lmask    = ~(32'hFFFF_FFFF << sh);
    assign lfull    = r_off >> sh;

    assign idx32    = 32'(r_idx);
    assign fsel_row = idx32[IRW+4:5];
    assign fsel_bit = idx32[4:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ibfsm_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_icnt   <= ICW'(INODE_COUNT);
            r_bcnt   <= BW'(BLOCK_COUNT - 1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_icnt   <= n_icnt;
            r_bcnt   <= n_bcnt;
            r_ovalid <= n_ovalid;
        end
        r_stat  <= n_stat;
        r_func  <= n_func;
        r_off   <= n_off;
        r_idx   <= n_idx;
        r_row   <= n_row;
        r_res   <= n_res;
        r_ostat <= n_ostat;
        r_oaddr <= n_oaddr;
    end

    always_comb begin
        n_state  = r_state;
        n_stat   = r_stat;
        n_clr    = r_clr;
        n_func   = r_func;
        n_off    = r_off;
        n_idx    = r_idx;
        n_row    = r_row;
        n_icnt   = r_icnt;
        n_bcnt   = r_bcnt;
        n_res    = r_res;
        n_ostat  = r_ostat;
        n_oaddr  = r_oaddr;
        n_ovalid = r_ovalid & ~i_m_tready;

        iwe    = 1'b0;
        iwaddr = r_row;
        iwdata = irdata;
        iraddr = r_row;
        bwe    = 1'b0;
        bwaddr = r_idx[BW-1:0];
        bwdata = 1'b0;
        braddr = r_idx[BW-1:0];
        swe    = 1'b0;
        swaddr = r_bcnt;
        swdata = r_idx[BW-1:0];
        sraddr = r_bcnt - BW'(1);

        unique case (r_state)
            ibfsm_pkg::ST_CLEAR: begin
                // Clear both bitmaps and load the stack so pops ascend from block 1.
                iwe    = (32'(r_clr) < 32'(IROWS));
                iwaddr = r_clr[IRW-1:0];
                iwdata = '0;
                bwe    = (32'(r_clr) < 32'(BLOCK_COUNT));
                bwaddr = r_clr[BW-1:0];
                bwdata = 1'b0;
                swe    = bwe;
                swaddr = r_clr[BW-1:0];
                swdata = BW'(BLOCK_COUNT - 1) - r_clr[BW-1:0];
                n_clr  = r_clr + CLW'(1);
                if (r_clr == CLW'(CLR_N - 1)) begin
                    n_state = ibfsm_pkg::ST_IDLE;
                end
            end
            ibfsm_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_func = i_func;
                    n_res  = '0;
                    n_stat = ibfsm_pkg::STAT_OK;
                    n_row  = '0;
                    unique case (i_func)
                        ibfsm_pkg::FN_ALLOC_INODE: begin
                            if (r_icnt == '0) begin
                                n_stat  = ibfsm_pkg::STAT_NONE_FREE;
                                n_state = ibfsm_pkg::ST_FIN;
                            end else begin
                                n_state = ibfsm_pkg::ST_IRD;
                            end
                        end
                        ibfsm_pkg::FN_FREE_INODE: begin
                            n_off   = i_addr - i_cfg.inode_base;
                            n_state = ibfsm_pkg::ST_LOC;
                        end
                        ibfsm_pkg::FN_ALLOC_BLOCK: begin
                            if (r_bcnt == '0) begin
                                n_stat  = ibfsm_pkg::STAT_NONE_FREE;
                                n_state = ibfsm_pkg::ST_FIN;
                            end else begin
                                n_state = ibfsm_pkg::ST_SRD;
                            end
                        end
                        default: begin
                            n_off   = i_addr - i_cfg.block_base;
                            n_state = ibfsm_pkg::ST_LOC;
                        end
                    endcase
                end
            end
            ibfsm_pkg::ST_LOC: begin
                n_idx = lfull[XW-1:0];
                if ((r_off & lmask) != '0 ||
                    lfull >= 32'(is_inode ? INODE_COUNT : BLOCK_COUNT)) begin
                    n_stat  = ibfsm_pkg::STAT_RANGE;
                    n_state = ibfsm_pkg::ST_FIN;
                end else if (is_inode && r_icnt >= ICW'(INODE_COUNT)) begin
                    n_stat  = ibfsm_pkg::STAT_NOTHING;
                    n_state = ibfsm_pkg::ST_FIN;
                end else if (!is_inode && r_bcnt >= BW'(BLOCK_COUNT - 1)) begin
                    n_stat  = ibfsm_pkg::STAT_NOTHING;
                    n_state = ibfsm_pkg::ST_FIN;
                end else begin
                    n_state = ibfsm_pkg::ST_FRD;
                end
            end
            ibfsm_pkg::ST_FRD: begin
                iraddr  = fsel_row;
                n_state = is_inode ? ibfsm_pkg::ST_IFREE : ibfsm_pkg::ST_BFREE;
            end
            ibfsm_pkg::ST_IFREE: begin
                if (!irdata[fsel_bit]) begin
                    n_stat = ibfsm_pkg::STAT_NOT_USED;
                end else begin
                    iwe    = 1'b1;
                    iwaddr = fsel_row;
                    iwdata = irdata & ~(32'd1 << fsel_bit);
                    n_icnt = r_icnt + ICW'(1);
                end
                n_state = ibfsm_pkg::ST_FIN;
            end
            ibfsm_pkg::ST_BFREE: begin
                if (!brdata) begin
                    n_stat = ibfsm_pkg::STAT_NOT_USED;
                end else begin
                    bwe    = 1'b1;
                    bwdata = 1'b0;
                    swe    = 1'b1;
                    n_bcnt = r_bcnt + BW'(1);
                end
                n_state = ibfsm_pkg::ST_FIN;
            end
            ibfsm_pkg::ST_IRD: begin
                n_state = ibfsm_pkg::ST_IEVAL;
            end
            ibfsm_pkg::ST_IEVAL: begin
                if (zfound) begin
                    iwe     = 1'b1;
                    iwdata  = irdata | (32'd1 << zpos);
                    n_icnt  = r_icnt - ICW'(1);
                    n_idx   = ifound[XW-1:0];
                    n_state = ibfsm_pkg::ST_SHIFT;
                end else if (32'(r_row) == 32'(IROWS - 1)) begin
                    n_stat  = ibfsm_pkg::STAT_NONE_FREE;
                    n_state = ibfsm_pkg::ST_FIN;
                end else begin
                    n_row   = r_row + IRW'(1);
                    n_state = ibfsm_pkg::ST_IRD;
                end
            end
            ibfsm_pkg::ST_SRD: begin
                n_state = ibfsm_pkg::ST_SPOP;
            end
            ibfsm_pkg::ST_SPOP: begin
                bwe     = 1'b1;
                bwaddr  = srdata;
                bwdata  = 1'b1;
                n_idx   = XW'(srdata);
                n_bcnt  = r_bcnt - BW'(1);
                n_state = ibfsm_pkg::ST_SHIFT;
            end
            ibfsm_pkg::ST_SHIFT: begin
                n_off   = idx32 << sh;
                n_state = ibfsm_pkg::ST_ADD;
            end
            ibfsm_pkg::ST_ADD: begin
                n_res   = r_off + (is_inode ? i_cfg.inode_base : i_cfg.block_base);
                n_state = ibfsm_pkg::ST_FIN;
            end
            ibfsm_pkg::ST_FIN: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_stat;
                    n_oaddr  = r_res;
                    n_state  = ibfsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ibfsm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
